// ----- sv/kwsm_pkg.sv -----
package kwsm_pkg;

  localparam int unsigned ShardsDef    = 8;
  localparam int unsigned ShardDepthDef = 1024;

  localparam int unsigned SelW    = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned TdataW  = 40;
  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_LOADED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_VALUE   = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TAKE = 1'b1
  } action_e;

endpackage

// ----- sv/kwsm_store.sv -----
module kwsm_store import kwsm_pkg::*; #(
  parameter int unsigned AW = 13
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [ValueW-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [2**AW];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/kwsm_cmp.sv -----
module kwsm_cmp import kwsm_pkg::*; #(
  parameter int unsigned SW = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              cand_valid_i,
  input  logic [ValueW-1:0] cand_value_i,
  input  logic [SW-1:0]     cand_shard_i,
  output logic              found_o,
  output logic [ValueW-1:0] best_value_o,
  output logic [SW-1:0]     best_shard_o
);

  logic              found_q, found_d;
  logic [ValueW-1:0] best_value_q, best_value_d;
  logic [SW-1:0]     best_shard_q, best_shard_d;
  logic              take_cand;

  // strict less keeps the lower shard on a tie since shards arrive in order
  assign take_cand = cand_valid_i &&
                     (!found_q || ($signed(cand_value_i) < $signed(best_value_q)));

  always_comb begin
    found_d      = found_q;
    best_value_d = best_value_q;
    best_shard_d = best_shard_q;
    if (clear_i) begin
      found_d = 1'b0;
    end else if (take_cand) begin
      found_d      = 1'b1;
      best_value_d = cand_value_i;
      best_shard_d = cand_shard_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_value_q <= best_value_d;
    best_shard_q <= best_shard_d;
  end

  assign found_o      = found_q;
  assign best_value_o = best_value_q;
  assign best_shard_o = best_shard_q;

endmodule

// ----- sv/k_way_sorted_merge_core.sv -----
// channel  | direction | tdata (low bit up)           | tuser
// s_axis   | in        | shard_sel[2:0], in_value     | action
// m_axis   | out       | out_value, from_shard[2:0]   | status
//
// a load answers from the load state; a take scans: one comparator
// visits the shard heads one per cycle behind a registered memory read,
// then drain passes the last head and done updates the winning read index.
// s_axis_tready is high only while idle; one result waits in the output
// register, and an item finishes only once that register is free.
// reset clears the fill counts and read indexes at once; no clearing pass.
module k_way_sorted_merge_core import kwsm_pkg::*; #(
  parameter int unsigned SHARDS      = ShardsDef,
  parameter int unsigned SHARD_DEPTH = ShardDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,   // shard_sel, in_value
  input  logic              s_axis_tuser,   // action
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,   // out_value, from_shard
  output logic [StatusW-1:0] m_axis_tuser   // status
);

  localparam int unsigned SW = $clog2(SHARDS);
  localparam int unsigned IW = $clog2(SHARD_DEPTH);
  localparam int unsigned CW = $clog2(SHARD_DEPTH + 1);
  localparam int unsigned AW = SW + IW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SelW-1:0]   sel_q;
  logic [ValueW-1:0] val_q;
  logic [SW-1:0]     scan_q, scan_d;
  logic [CW-1:0]     fill_q [SHARDS];
  logic [CW-1:0]     rd_q   [SHARDS];

  logic              out_valid_q;
  status_e           out_status_q;
  logic [ValueW-1:0] out_value_q;
  logic [SelW-1:0]   out_from_q;

  logic              in_xfer, out_free;
  logic [SW-1:0]     sel_idx, idx;
  logic [CW-1:0]     cur_fill, cur_rd;
  logic              sel_ok, full, nonempty, load_ok;
  logic              cand_valid_q;
  logic [SW-1:0]     cand_shard_q;
  logic [ValueW-1:0] rdata;
  logic              found;
  logic [ValueW-1:0] best_value;
  logic [SW-1:0]     best_shard;
  logic              finish;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign sel_idx = SW'(sel_q);
  assign sel_ok  = (int'(sel_q) < int'(SHARDS));

  always_comb begin
    case (state_q)
      S_SCAN:  idx = scan_q;
      S_DONE:  idx = best_shard;
      default: idx = sel_idx;
    endcase
  end

  assign cur_fill = fill_q[idx];
  assign cur_rd   = rd_q[idx];
  assign full     = (cur_fill == CW'(SHARD_DEPTH));
  assign nonempty = (cur_rd < cur_fill);
  assign load_ok  = sel_ok && !full;
  assign finish   = ((state_q == S_LOAD) || (state_q == S_DONE)) && out_free;

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          scan_d  = '0;
          state_d = (s_axis_tuser == ACT_TAKE) ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == SW'(SHARDS - 1)) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_q       <= '0;
      cand_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < int'(SHARDS); i++) begin
        fill_q[i] <= '0;
        rd_q[i]   <= '0;
      end
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      cand_valid_q <= (state_q == S_SCAN) && nonempty;
      if (state_q == S_LOAD && out_free && load_ok) begin
        fill_q[idx] <= cur_fill + 1'b1;
      end
      if (state_q == S_DONE && out_free && found) begin
        rd_q[idx] <= cur_rd + 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sel_q <= s_axis_tdata[SelW-1:0];
      val_q <= s_axis_tdata[SelW +: ValueW];
    end
    cand_shard_q <= scan_q;
    if (finish) begin
      if (state_q == S_LOAD) begin
        out_status_q <= load_ok ? ST_LOADED : ST_DROPPED;
        out_value_q  <= '0;
        out_from_q   <= '0;
      end else if (found) begin
        out_status_q <= ST_VALUE;
        out_value_q  <= best_value;
        out_from_q   <= SelW'(best_shard);
      end else begin
        out_status_q <= ST_EMPTY;
        out_value_q  <= '0;
        out_from_q   <= '0;
      end
    end
  end

  kwsm_store #(
    .AW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_LOAD) && out_free && load_ok),
    .waddr_i ({sel_idx, cur_fill[IW-1:0]}),
    .wdata_i (val_q),
    .raddr_i ({scan_q, cur_rd[IW-1:0]}),
    .rdata_o (rdata)
  );

  kwsm_cmp #(
    .SW (SW)
  ) u_cmp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (in_xfer),
    .cand_valid_i (cand_valid_q),
    .cand_value_i (rdata),
    .cand_shard_i (cand_shard_q),
    .found_o      (found),
    .best_value_o (best_value),
    .best_shard_o (best_shard)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(TdataW - ValueW - SelW)'(0), out_from_q, out_value_q};

endmodule

// ----- sv/kwsm_checker.sv -----
module kwsm_checker import kwsm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               s_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TdataW-1:0]  m_axis_tdata,
  input logic [StatusW-1:0] m_axis_tuser
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // busy right after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after input transfer");

  // a take scans the shards, so ready is still low while the scan runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_TAKE) |-> ##2 !s_axis_tready)
    else $error("take finished too early");

  // only a returned value carries data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_VALUE) |-> (m_axis_tdata == '0))
    else $error("nonzero data without a returned value");

  // a new result never rises straight out of the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind k_way_sorted_merge_core kwsm_checker u_kwsm_checker (.*);
